/* src/kwc_pkg.sv */
package kwc_pkg;

   localparam int MAX_WINDOW    = 8;
   localparam int TABLE_DEPTH   = 4096;
   localparam int POSITION_BITS = 24;

   localparam int SYM_BITS      = 3;
   localparam int READ_IDX_BITS = 12;
   localparam int COUNT_BITS    = 32;
   localparam int CFG_POS_BITS  = 24;
   localparam int CSR_IDX_BITS  = 3;

   localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
   localparam int LEN_BITS      = $clog2(MAX_WINDOW + 1);
   localparam int WIN_IDX_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   localparam int IDX_A         = SYM_BITS * MAX_WINDOW;
   localparam int IDX_B         = (ADDR_BITS > READ_IDX_BITS) ? ADDR_BITS + 1 : READ_IDX_BITS + 1;
   localparam int IDX_BITS      = (IDX_A > IDX_B) ? IDX_A : IDX_B;

   localparam int CMP_BITS      = (POSITION_BITS > CFG_POS_BITS) ?
                                  POSITION_BITS + 1 : CFG_POS_BITS + 1;

   localparam logic [1:0] REQ_SYMBOL  = 2'd0;
   localparam logic [1:0] REQ_RESTART = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   localparam logic MODE_WMM = 1'b0;
   localparam logic MODE_LUT = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_COUNT_MODE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LENGTH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHABET_SIZE = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FOCUS_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_POSITION  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_POSITION  = 3'd5;

   typedef logic [MAX_WINDOW-1:0][SYM_BITS-1:0] sym_window_type;

   typedef struct packed {
      logic                 bump;
      logic                 clear;
      logic                 rd;
      logic [ADDR_BITS-1:0] addr;
   } mem_cmd_type;

   typedef struct packed {
      logic                     full;
      logic [POSITION_BITS:0]   pos;
   } eval_type;

endpackage

/* src/kwc_ram.sv */
module kwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/kwc_rmw.sv */
module kwc_rmw (
   input  logic                            clock,
   input  logic                            reset,
   input  kwc_pkg::mem_cmd_type            cmd,
   output logic [kwc_pkg::COUNT_BITS-1:0]  rd_data
);

   logic                            wb_valid_ff, wb_valid_in;
   logic [kwc_pkg::ADDR_BITS-1:0]   wb_addr_ff, wb_addr_in;
   logic                            fwd_ff, fwd_in;
   logic [kwc_pkg::COUNT_BITS-1:0]  last_data_ff, last_data_in;
   logic [kwc_pkg::COUNT_BITS-1:0]  ram_rd_data;
   logic [kwc_pkg::COUNT_BITS-1:0]  cur;
   logic                            wr_en;
   logic [kwc_pkg::ADDR_BITS-1:0]   wr_addr;
   logic [kwc_pkg::COUNT_BITS-1:0]  wr_data;

   // back-to-back bumps of the same entry see the value still being written
   always_comb begin
      wb_valid_in  = cmd.bump;
      wb_addr_in   = cmd.addr;
      fwd_in       = cmd.bump && wb_valid_ff && (wb_addr_ff == cmd.addr);
      cur          = fwd_ff ? last_data_ff : ram_rd_data;
      last_data_in = (cur == '1) ? cur : cur + kwc_pkg::COUNT_BITS'(1);
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = cmd.addr;
         wr_data = '0;
      end else begin
         wr_en   = wb_valid_ff;
         wr_addr = wb_addr_ff;
         wr_data = last_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         wb_valid_ff <= wb_valid_in;
         fwd_ff      <= fwd_in;
      end
      wb_addr_ff   <= wb_addr_in;
      last_data_ff <= last_data_in;
   end

   kwc_ram #(
      .WIDTH (kwc_pkg::COUNT_BITS),
      .DEPTH (kwc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.bump | cmd.rd),
      .rd_addr (cmd.addr),
      .rd_data (ram_rd_data)
   );

   assign rd_data = ram_rd_data;

endmodule

/* src/kwc_window.sv */
module kwc_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift,
   input  logic                              restart,
   input  logic [kwc_pkg::SYM_BITS-1:0]      symbol,
   input  logic [kwc_pkg::LEN_BITS-1:0]      len_eff,
   input  logic [2:0]                        focus_offset,
   output kwc_pkg::sym_window_type           window,
   output kwc_pkg::eval_type                 eval
);

   kwc_pkg::sym_window_type                win_ff, win_in;
   logic [kwc_pkg::POSITION_BITS-1:0]      pos_ff, pos_in;
   logic [kwc_pkg::LEN_BITS-1:0]           seen_ff, seen_in;
   kwc_pkg::eval_type                      eval_ff, eval_in;
   logic [kwc_pkg::POSITION_BITS:0]        next_pos;

   always_comb begin
      win_in   = win_ff;
      pos_in   = pos_ff;
      seen_in  = seen_ff;
      eval_in  = eval_ff;
      next_pos = (kwc_pkg::POSITION_BITS+1)'(pos_ff) + (kwc_pkg::POSITION_BITS+1)'(1);
      if (restart) begin
         win_in  = '0;
         pos_in  = '0;
         seen_in = '0;
      end else if (shift) begin
         for (int k = 0; k < kwc_pkg::MAX_WINDOW - 1; k++) begin
            win_in[k] = win_ff[k+1];
         end
         win_in[kwc_pkg::MAX_WINDOW-1] = symbol;
         pos_in = next_pos[kwc_pkg::POSITION_BITS-1:0];
         if (32'(seen_ff) < kwc_pkg::MAX_WINDOW) begin
            seen_in = seen_ff + kwc_pkg::LEN_BITS'(1);
         end
         eval_in.full = (seen_in >= len_eff) &&
                        (next_pos >= (kwc_pkg::POSITION_BITS+1)'(len_eff));
         eval_in.pos  = next_pos - (kwc_pkg::POSITION_BITS+1)'(len_eff)
                        + (kwc_pkg::POSITION_BITS+1)'(focus_offset);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         pos_ff  <= '0;
         seen_ff <= '0;
      end else begin
         win_ff  <= win_in;
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
      end
      eval_ff <= eval_in;
   end

   assign window = win_ff;
   assign eval   = eval_ff;

endmodule

/* src/kmer_window_counter_core.sv */
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/tready    | tuser: req_type; tdata: symbol, read_index
// rsp     | out       | rsp_tvalid/tready    | tuser: counted, index_overflow; tdata: read_count
// csr     | in        | csr_valid/ready      | csr_index, csr_data
//
// one transaction at a time; a restart goes IDLE then DONE, a read IDLE, READ then DONE
// a counted symbol goes EVAL then BUMP (wmm, one table update per cycle through the
// read-modify-write port) or EVAL, LUT, LCHK then BUMP (lut, one digit per cycle)
// after reset the table is cleared one entry per cycle, every entry, with req_tready low
// a pending response does not block acceptance; a stalled rsp side holds the final state
module kmer_window_counter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // symbol, read_index, pad
   input  logic [1:0]                         req_tuser,   // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [kwc_pkg::COUNT_BITS-1:0]     rsp_tdata,   // read_count
   output logic [1:0]                         rsp_tuser,   // counted, index_overflow
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kwc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [kwc_pkg::CFG_POS_BITS-1:0]   csr_data
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_LUT   = 3'd3;
   localparam logic [2:0] S_LCHK  = 3'd4;
   localparam logic [2:0] S_BUMP  = 3'd5;
   localparam logic [2:0] S_READ  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic                                mode_ff;
   logic [3:0]                          wlen_ff;
   logic [2:0]                          base_ff;
   logic [2:0]                          focus_ff;
   logic [kwc_pkg::CFG_POS_BITS-1:0]    min_ff;
   logic [kwc_pkg::CFG_POS_BITS-1:0]    max_ff;

   logic [2:0]                          state_ff, state_in;
   logic [kwc_pkg::LEN_BITS-1:0]        step_ff, step_in;
   logic [kwc_pkg::IDX_BITS-1:0]        lut_idx_ff, lut_idx_in;
   logic [kwc_pkg::ADDR_BITS-1:0]       clr_addr_ff, clr_addr_in;
   logic                                res_counted_ff, res_counted_in;
   logic                                res_ovf_ff, res_ovf_in;
   logic [kwc_pkg::COUNT_BITS-1:0]      res_count_ff, res_count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_counted_ff, rsp_counted_in;
   logic                                rsp_ovf_ff, rsp_ovf_in;
   logic [kwc_pkg::COUNT_BITS-1:0]      rsp_count_ff, rsp_count_in;

   logic                                accept;
   logic [1:0]                          req_type;
   logic [kwc_pkg::SYM_BITS-1:0]        symbol;
   logic [kwc_pkg::READ_IDX_BITS-1:0]   read_index;
   logic [kwc_pkg::LEN_BITS-1:0]        len_eff;
   logic [kwc_pkg::LEN_BITS-1:0]        first;
   logic [kwc_pkg::LEN_BITS-1:0]        sym_sel;
   logic [kwc_pkg::SYM_BITS-1:0]        sym_at;
   logic [kwc_pkg::IDX_BITS-1:0]        base_ext;
   logic [kwc_pkg::IDX_BITS-1:0]        bump_idx;
   logic                                in_range;
   logic                                wmm_bad;
   logic                                out_free;
   logic                                last_step;
   kwc_pkg::sym_window_type             window;
   kwc_pkg::eval_type                   eval;
   kwc_pkg::mem_cmd_type                cmd;
   logic [kwc_pkg::COUNT_BITS-1:0]      rd_data;

   assign req_type   = req_tuser;
   assign symbol     = req_tdata[2:0];
   assign read_index = req_tdata[14:3];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= kwc_pkg::MODE_WMM;
         wlen_ff  <= 4'd1;
         base_ff  <= 3'd5;
         focus_ff <= 3'd0;
         min_ff   <= '0;
         max_ff   <= '1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            kwc_pkg::CSR_COUNT_MODE:    mode_ff  <= csr_data[0];
            kwc_pkg::CSR_WINDOW_LENGTH: wlen_ff  <= csr_data[3:0];
            kwc_pkg::CSR_ALPHABET_SIZE: base_ff  <= csr_data[2:0];
            kwc_pkg::CSR_FOCUS_OFFSET:  focus_ff <= csr_data[2:0];
            kwc_pkg::CSR_MIN_POSITION:  min_ff   <= csr_data;
            kwc_pkg::CSR_MAX_POSITION:  max_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (wlen_ff == 4'd0) begin
         len_eff = kwc_pkg::LEN_BITS'(1);
      end else if (32'(wlen_ff) > kwc_pkg::MAX_WINDOW) begin
         len_eff = kwc_pkg::LEN_BITS'(kwc_pkg::MAX_WINDOW);
      end else begin
         len_eff = kwc_pkg::LEN_BITS'(wlen_ff);
      end
   end

   kwc_window u_window (
      .clock        (clock),
      .reset        (reset),
      .shift        (accept && (req_type == kwc_pkg::REQ_SYMBOL)),
      .restart      (accept && (req_type == kwc_pkg::REQ_RESTART)),
      .symbol       (symbol),
      .len_eff      (len_eff),
      .focus_offset (focus_ff),
      .window       (window),
      .eval         (eval)
   );

   // window offsets checked side by side, oldest counted symbol at index first
   always_comb begin
      logic [kwc_pkg::LEN_BITS-1:0] off;
      logic [kwc_pkg::IDX_BITS-1:0] widx;
      first    = kwc_pkg::LEN_BITS'(kwc_pkg::MAX_WINDOW) - len_eff;
      base_ext = kwc_pkg::IDX_BITS'(base_ff);
      wmm_bad  = 1'b0;
      for (int j = 0; j < kwc_pkg::MAX_WINDOW; j++) begin
         off  = kwc_pkg::LEN_BITS'(j) - first;
         widx = kwc_pkg::IDX_BITS'(off) * base_ext + kwc_pkg::IDX_BITS'(window[j]);
         if ((kwc_pkg::LEN_BITS'(j) >= first) &&
             (widx >= kwc_pkg::IDX_BITS'(kwc_pkg::TABLE_DEPTH))) begin
            wmm_bad = 1'b1;
         end
      end
      sym_sel  = first + step_ff;
      sym_at   = window[sym_sel[kwc_pkg::WIN_IDX_BITS-1:0]];
      in_range = eval.full &&
                 (kwc_pkg::CMP_BITS'(eval.pos) >= kwc_pkg::CMP_BITS'(min_ff)) &&
                 (kwc_pkg::CMP_BITS'(eval.pos) <= kwc_pkg::CMP_BITS'(max_ff));
      if (mode_ff == kwc_pkg::MODE_LUT) begin
         bump_idx = lut_idx_ff;
      end else begin
         bump_idx = kwc_pkg::IDX_BITS'(step_ff) * base_ext + kwc_pkg::IDX_BITS'(sym_at);
      end
      last_step = (step_ff == len_eff - kwc_pkg::LEN_BITS'(1));
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      lut_idx_in     = lut_idx_ff;
      clr_addr_in    = clr_addr_ff;
      res_counted_in = res_counted_ff;
      res_ovf_in     = res_ovf_ff;
      res_count_in   = res_count_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_counted_in = rsp_counted_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_count_in   = rsp_count_ff;
      cmd            = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.addr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + kwc_pkg::ADDR_BITS'(1);
            if (32'(clr_addr_ff) == kwc_pkg::TABLE_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               res_counted_in = 1'b0;
               res_count_in   = '0;
               res_ovf_in     = (req_type == kwc_pkg::REQ_READ) &&
                                (kwc_pkg::IDX_BITS'(read_index) >=
                                 kwc_pkg::IDX_BITS'(kwc_pkg::TABLE_DEPTH));
               case (req_type)
                  kwc_pkg::REQ_SYMBOL: state_in = S_EVAL;
                  kwc_pkg::REQ_READ: begin
                     cmd.rd   = 1'b1;
                     cmd.addr = kwc_pkg::ADDR_BITS'(read_index);
                     state_in = S_READ;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_EVAL: begin
            step_in    = '0;
            lut_idx_in = '0;
            if (!in_range) begin
               state_in = S_DONE;
            end else if (mode_ff == kwc_pkg::MODE_LUT) begin
               state_in = S_LUT;
            end else if (wmm_bad) begin
               res_ovf_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_BUMP;
            end
         end
         S_LUT: begin
            lut_idx_in = lut_idx_ff * base_ext + kwc_pkg::IDX_BITS'(sym_at);
            step_in    = step_ff + kwc_pkg::LEN_BITS'(1);
            if (last_step) begin
               state_in = S_LCHK;
            end
         end
         S_LCHK: begin
            step_in = '0;
            if (lut_idx_ff >= kwc_pkg::IDX_BITS'(kwc_pkg::TABLE_DEPTH)) begin
               res_ovf_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_BUMP;
            end
         end
         S_BUMP: begin
            cmd.bump = 1'b1;
            cmd.addr = bump_idx[kwc_pkg::ADDR_BITS-1:0];
            step_in  = step_ff + kwc_pkg::LEN_BITS'(1);
            if ((mode_ff == kwc_pkg::MODE_LUT) || last_step) begin
               res_counted_in = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_READ: begin
            if (!res_ovf_ff) begin
               res_count_in = rd_data;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_counted_in = res_counted_ff;
               rsp_ovf_in     = res_ovf_ff;
               rsp_count_in   = res_count_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff        <= step_in;
      lut_idx_ff     <= lut_idx_in;
      res_counted_ff <= res_counted_in;
      res_ovf_ff     <= res_ovf_in;
      res_count_ff   <= res_count_in;
      rsp_counted_ff <= rsp_counted_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      rsp_count_ff   <= rsp_count_in;
   end

   kwc_rmw u_rmw (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_counted_ff};

endmodule
